// ----- sv/bsdc_pkg.sv -----
// bsdc_pkg: constants, calendar tables and shared types for the Bikram Sambat
// date converter. No dependencies; used by bsdc_walk and the top level.
`default_nettype none

package bsdc_pkg;

    localparam int CYCLE_YEARS = 139;
    // 139 * 365 + 36 leap years of the pattern table
    localparam int CYCLE_DAYS  = 50771;
    localparam int BASE_YEAR   = 2060;
    localparam int MAX_SHIFT   = 1439;
    localparam int ZONE_RESET  = 195;

    localparam int DAY_W   = 21;
    localparam int ZONE_W  = 11;
    localparam int YEAR_W  = 14;     // internal signed year
    localparam int REM_W   = 23;     // signed day remainder
    localparam int PIDX_W  = 8;

    // reciprocal of 60 for the zone split, corrected afterwards
    localparam int DIV60_MUL   = 1093;
    localparam int DIV60_SHIFT = 16;

    localparam logic [3:0] PAT_B      = 4'd4;
    localparam logic [3:0] PAT_G      = 4'd5;
    localparam logic [3:0] MONTH_LAST = 4'd12;

    localparam logic [3:0] YEAR_PAT [CYCLE_YEARS] = '{
        4'd1, 4'd4, 4'd10, 4'd12, 4'd1, 4'd4, 4'd8, 4'd12, 4'd1, 4'd4, 4'd7, 4'd12,
        4'd2, 4'd4, 4'd6, 4'd12, 4'd3, 4'd5, 4'd6, 4'd12, 4'd3, 4'd5, 4'd12, 4'd12,
        4'd4, 4'd11, 4'd12,
        4'd1, 4'd4, 4'd10, 4'd12, 4'd1, 4'd4, 4'd8, 4'd12, 4'd1, 4'd4, 4'd7, 4'd12,
        4'd1, 4'd4, 4'd6, 4'd12, 4'd3, 4'd5, 4'd6, 4'd12, 4'd3, 4'd5, 4'd12, 4'd12,
        4'd4, 4'd11, 4'd12,
        4'd1, 4'd4, 4'd11, 4'd12, 4'd1, 4'd4, 4'd9, 4'd12, 4'd1, 4'd4, 4'd7, 4'd12,
        4'd1, 4'd4, 4'd7, 4'd12, 4'd2, 4'd5, 4'd6, 4'd12, 4'd3, 4'd5, 4'd12, 4'd12,
        4'd3, 4'd5, 4'd12,
        4'd0, 4'd4, 4'd11, 4'd12, 4'd1, 4'd4, 4'd9, 4'd12, 4'd1, 4'd4, 4'd7, 4'd12,
        4'd1, 4'd4, 4'd7, 4'd12, 4'd2, 4'd4, 4'd6, 4'd12, 4'd3, 4'd5, 4'd12, 4'd12,
        4'd3, 4'd5, 4'd12,
        4'd0, 4'd4, 4'd11, 4'd12, 4'd1, 4'd4, 4'd9, 4'd12, 4'd1, 4'd4, 4'd7, 4'd12,
        4'd1, 4'd4, 4'd7, 4'd12, 4'd2, 4'd4, 4'd6, 4'd12, 4'd3, 4'd5, 4'd6, 4'd12,
        4'd3, 4'd5, 4'd12,
        4'd0, 4'd4, 4'd11, 4'd12
    };

    // extra-day bit per month, leftmost is Baishak
    localparam logic [0:11] MONTH_BITS [13] = '{
        12'b101010101010,
        12'b101100101010,
        12'b110100101010,
        12'b110100110010,
        12'b110100110011,
        12'b110100110101,
        12'b100101101010,
        12'b100101011010,
        12'b100101011001,
        12'b100101010101,
        12'b010101010101,
        12'b010100110101,
        12'b101001101010
    };

    localparam logic [5:0] BASE_LEN [12] = '{
        6'd30, 6'd31, 6'd31, 6'd31, 6'd31, 6'd30,
        6'd29, 6'd29, 6'd29, 6'd29, 6'd29, 6'd30
    };

    typedef struct packed {
        logic [DAY_W-1:0]  day_offset;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [5:0]        second;
        logic              with_time;
        logic [ZONE_W-1:0] zone;
    } walk_req_t;

    typedef struct packed {
        logic [12:0] year;
        logic [3:0]  month;
        logic [5:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } walk_res_t;

    typedef struct packed {
        logic start;
        logic ack;
    } walk_ctl_t;

    typedef struct packed {
        logic ready;
        logic done;
    } walk_stat_t;

    function automatic logic [8:0] year_days(input logic [PIDX_W-1:0] idx);
        logic [3:0] p;
        p = YEAR_PAT[idx];
        return (p == PAT_B || p == PAT_G) ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [5:0] month_days(input logic [3:0] pat,
                                              input logic [3:0] mon_idx);
        return BASE_LEN[mon_idx] + {5'd0, MONTH_BITS[pat][mon_idx]};
    endfunction

endpackage

`default_nettype wire

// ----- sv/bsdc_walk.sv -----
// bsdc_walk: sequencer around one shared adder; zone shift, cycle/year/month walk.
// Depends on bsdc_pkg.
`default_nettype none

module bsdc_walk (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bsdc_pkg::walk_ctl_t ctl,
    input  wire bsdc_pkg::walk_req_t req,
    output bsdc_pkg::walk_stat_t     stat,
    output bsdc_pkg::walk_res_t      res
);

    localparam logic [2:0] W_IDLE  = 3'd0;
    localparam logic [2:0] W_DIV   = 3'd1;
    localparam logic [2:0] W_TIME  = 3'd2;
    localparam logic [2:0] W_CYC   = 3'd3;
    localparam logic [2:0] W_YEAR  = 3'd4;
    localparam logic [2:0] W_MONTH = 3'd5;
    localparam logic [2:0] W_DONE  = 3'd6;

    localparam int RW = bsdc_pkg::REM_W;
    localparam int YW = bsdc_pkg::YEAR_W;
    localparam int PW = bsdc_pkg::PIDX_W;
    localparam int ZW = bsdc_pkg::ZONE_W;

    localparam logic signed [RW-1:0] CYC_DAYS  = RW'(bsdc_pkg::CYCLE_DAYS);
    localparam logic signed [YW-1:0] CYC_YEARS = YW'(bsdc_pkg::CYCLE_YEARS);
    localparam logic [PW-1:0]        PIDX_LAST = PW'(bsdc_pkg::CYCLE_YEARS - 1);
    localparam logic [ZW-1:0]        ZONE_MAX  = ZW'(bsdc_pkg::MAX_SHIFT);

    logic [2:0]              state_reg, state_next;
    logic [ZW-1:0]           zone_reg, zone_next;
    logic [4:0]              q_reg, q_next;
    logic [bsdc_pkg::DAY_W-1:0] day_reg, day_next;
    logic [4:0]              hour_reg, hour_next;
    logic [5:0]              min_reg, min_next;
    logic [5:0]              sec_reg, sec_next;
    logic                    wt_reg, wt_next;
    logic                    back_reg, back_next;
    logic signed [RW-1:0]    rem_reg, rem_next;
    logic signed [YW-1:0]    year_reg, year_next;
    logic [PW-1:0]           pidx_reg, pidx_next;
    logic [3:0]              month_reg, month_next;
    logic [4:0]              lh_reg, lh_next;
    logic [5:0]              lm_reg, lm_next;

    // time shift
    logic [2*ZW-1:0]         prod;
    logic [ZW-1:0]           qx60;
    logic [ZW-1:0]           zrem;
    logic [4:0]              zh;
    logic [5:0]              zm;
    logic signed [7:0]       lm8;
    logic signed [7:0]       lh8;
    logic signed [7:0]       lm_fix;
    logic signed [7:0]       lh_fix;
    logic                    borrow_m;
    logic                    borrow_d;
    logic                    apply;
    logic signed [RW-1:0]    rem_init;

    // shared adder
    logic [PW-1:0]           pidx_inc, pidx_dec;
    logic [8:0]              ylen;
    logic [5:0]              mlen;
    logic signed [RW-1:0]    operand;
    logic signed [RW-1:0]    sum;

    assign prod = {{ZW{1'b0}}, zone_reg} * (2*ZW)'(bsdc_pkg::DIV60_MUL);

    always_comb
    begin
        qx60     = {{(ZW-5){1'b0}}, q_reg} * ZW'(60);
        zrem     = zone_reg - qx60;
        if (zrem >= ZW'(60))
        begin
            zh = q_reg + 5'd1;
            zm = 6'(zrem - ZW'(60));
        end
        else
        begin
            zh = q_reg;
            zm = 6'(zrem);
        end
        lm8      = $signed({2'b00, min_reg}) - $signed({2'b00, zm});
        borrow_m = lm8[7];
        lm_fix   = borrow_m ? lm8 + 8'sd60 : lm8;
        lh8      = $signed({3'b000, hour_reg}) - $signed({3'b000, zh})
                   - $signed({7'd0, borrow_m});
        lh_fix   = lh8[7] ? lh8 + 8'sd24 : lh8;
        apply    = wt_reg || (hour_reg != 5'd0) || (min_reg != 6'd0) || (sec_reg != 6'd0);
        borrow_d = apply && lh8[7];
        rem_init = $signed({{(RW-bsdc_pkg::DAY_W){day_reg[bsdc_pkg::DAY_W-1]}}, day_reg})
                   - $signed({{(RW-1){1'b0}}, borrow_d});
    end

    always_comb
    begin
        pidx_inc = (pidx_reg == PIDX_LAST) ? '0 : pidx_reg + PW'(1);
        pidx_dec = (pidx_reg == '0) ? PIDX_LAST : pidx_reg - PW'(1);
        ylen     = bsdc_pkg::year_days(back_reg ? pidx_dec : pidx_reg);
        mlen     = bsdc_pkg::month_days(bsdc_pkg::YEAR_PAT[pidx_reg], month_reg - 4'd1);
        case (state_reg)
            W_CYC:   operand = back_reg ? CYC_DAYS : -CYC_DAYS;
            W_YEAR:  operand = back_reg ? $signed({{(RW-9){1'b0}}, ylen})
                                        : -$signed({{(RW-9){1'b0}}, ylen});
            W_MONTH: operand = -$signed({{(RW-6){1'b0}}, mlen});
            default: operand = '0;
        endcase
        sum = rem_reg + operand;
    end

    always_comb
    begin
        state_next = state_reg;
        zone_next  = zone_reg;
        q_next     = q_reg;
        day_next   = day_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;
        wt_next    = wt_reg;
        back_next  = back_reg;
        rem_next   = rem_reg;
        year_next  = year_reg;
        pidx_next  = pidx_reg;
        month_next = month_reg;
        lh_next    = lh_reg;
        lm_next    = lm_reg;
        case (state_reg)
            W_IDLE:
            begin
                if (ctl.start)
                begin
                    zone_next  = (req.zone > ZONE_MAX) ? ZONE_MAX : req.zone;
                    day_next   = req.day_offset;
                    hour_next  = req.hour;
                    min_next   = req.minute;
                    sec_next   = req.second;
                    wt_next    = req.with_time;
                    state_next = W_DIV;
                end
            end
            W_DIV:
            begin
                q_next     = prod[bsdc_pkg::DIV60_SHIFT +: 5];
                state_next = W_TIME;
            end
            W_TIME:
            begin
                lh_next    = apply ? lh_fix[4:0] : hour_reg;
                lm_next    = apply ? lm_fix[5:0] : min_reg;
                rem_next   = rem_init;
                back_next  = rem_init[RW-1];
                year_next  = YW'(bsdc_pkg::BASE_YEAR);
                pidx_next  = '0;    // (2060 + 25) mod 139
                state_next = W_CYC;
            end
            W_CYC:
            begin
                // skip whole 139-year cycles
                if (sum[RW-1] == back_reg)
                begin
                    rem_next  = sum;
                    year_next = back_reg ? year_reg - CYC_YEARS : year_reg + CYC_YEARS;
                end
                else
                begin
                    state_next = W_YEAR;
                end
            end
            W_YEAR:
            begin
                if (!back_reg && !sum[RW-1])
                begin
                    rem_next  = sum;
                    year_next = year_reg + YW'(1);
                    pidx_next = pidx_inc;
                end
                else if (back_reg && rem_reg[RW-1])
                begin
                    rem_next  = sum;
                    year_next = year_reg - YW'(1);
                    pidx_next = pidx_dec;
                end
                else
                begin
                    month_next = 4'd1;
                    state_next = W_MONTH;
                end
            end
            W_MONTH:
            begin
                if (!sum[RW-1] && month_reg != bsdc_pkg::MONTH_LAST)
                begin
                    rem_next   = sum;
                    month_next = month_reg + 4'd1;
                end
                else
                begin
                    state_next = W_DONE;
                end
            end
            W_DONE:
            begin
                if (ctl.ack)
                begin
                    state_next = W_IDLE;
                end
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zone_reg  <= zone_next;
        q_reg     <= q_next;
        day_reg   <= day_next;
        hour_reg  <= hour_next;
        min_reg   <= min_next;
        sec_reg   <= sec_next;
        wt_reg    <= wt_next;
        back_reg  <= back_next;
        rem_reg   <= rem_next;
        year_reg  <= year_next;
        pidx_reg  <= pidx_next;
        month_reg <= month_next;
        lh_reg    <= lh_next;
        lm_reg    <= lm_next;
    end

    assign stat.ready = (state_reg == W_IDLE);
    assign stat.done  = (state_reg == W_DONE);

    assign res.year   = year_reg[12:0];
    assign res.month  = month_reg;
    assign res.day    = rem_reg[5:0] + 6'd1;
    assign res.hour   = lh_reg;
    assign res.minute = lm_reg;
    assign res.second = sec_reg;

endmodule

`default_nettype wire

// ----- sv/bikram_sambat_date_convert_unit.sv -----
// Top level of the Bikram Sambat date converter: stream ports, zone register,
// output register. Depends on bsdc_pkg and bsdc_walk.
//
//  channel   | dir | handshake                      | content
//  ----------+-----+--------------------------------+-------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready  | day offset, time, with_time
//  m_axis    | out | m_axis_tvalid / m_axis_tready  | BS year/month/day, local time
//  cfg       | in  | cfg_wr_en (no wait)            | zone_shift_minutes
//
// One transaction in, one transaction out. A conversion steps through the
// quotient, the time shift, the skipped 139-year cycles (up to 20) and the last
// cycle test, the remaining years (up to 139) and the last year test, the months
// (up to 12) and done; the cycle, year and month steps all go through the
// single adder in bsdc_walk.
// s_axis_tready is high only while the walk unit is idle. A finished result
// sits in the walk unit until the output register is free, so a stalled
// m_axis holds back the next conversion but loses nothing.
// Reset: zone shift returns to 195 minutes (3 h 15 min), no result pending.
`default_nettype none

module bikram_sambat_date_convert_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [10:0] cfg_wr_data,   // zone_shift_minutes
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [20:0] day_offset, [25:21] hour_in, [31:26] minute_in, [37:32] second_in,
    // [39:38] zero
    input  wire logic [39:0] s_axis_tdata,
    input  wire logic        s_axis_tuser,  // with_time
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [12:0] bs_year, [16:13] bs_month, [22:17] bs_day, [27:23] local_hour,
    // [33:28] local_minute, [39:34] local_second
    output logic [39:0]      m_axis_tdata
);

    logic [bsdc_pkg::ZONE_W-1:0] zone_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [39:0]                 out_data_reg;

    bsdc_pkg::walk_ctl_t  ctl;
    bsdc_pkg::walk_req_t  req;
    bsdc_pkg::walk_stat_t stat;
    bsdc_pkg::walk_res_t  res;
    logic                 load_out;

    // config register; only to be written while idle, which the block itself does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg <= bsdc_pkg::ZONE_W'(bsdc_pkg::ZONE_RESET);
        end
        else if (cfg_wr_en)
        begin
            zone_reg <= cfg_wr_data;
        end
    end

    assign s_axis_tready = stat.ready;

    assign req.day_offset = s_axis_tdata[20:0];
    assign req.hour       = s_axis_tdata[25:21];
    assign req.minute     = s_axis_tdata[31:26];
    assign req.second     = s_axis_tdata[37:32];
    assign req.with_time  = s_axis_tuser;
    assign req.zone       = zone_reg;

    // result moves over when the output slot is empty or being drained
    assign load_out  = stat.done && (!out_valid_reg || m_axis_tready);
    assign ctl.start = s_axis_tvalid && s_axis_tready;
    assign ctl.ack   = load_out;

    bsdc_walk u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .req   (req),
        .stat  (stat),
        .res   (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= {res.second, res.minute, res.hour, res.day, res.month, res.year};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ----- sv/bsdc_checker.sv -----
// bsdc_checker: port-level assertions for the date converter, bound to the top.
// Depends on bikram_sambat_date_convert_unit ports only.
`default_nettype none

module bsdc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or dropped while stalled");

    // the walk unit is busy right after taking a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    // a new result only appears after the unit has been busy
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a conversion");

    // month is always a real month
    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[16:13] >= 4'd1 && m_axis_tdata[16:13] <= 4'd12)
        else $error("month out of range");

endmodule

bind bikram_sambat_date_convert_unit bsdc_checker u_bsdc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
